@@ rtl/core/mono_framebuffer_line_writer_top_macros.svh @@
// Assertion macros for the monochrome frame store line writer.
// Used by the port checker; expects clk and arst_n in scope.
`ifndef MONO_FRAMEBUFFER_LINE_WRITER_TOP_MACROS_SVH
`define MONO_FRAMEBUFFER_LINE_WRITER_TOP_MACROS_SVH

// same-cycle implication
`define MFB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MFB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/mfb_lw_pkg.sv @@
// Package for the monochrome frame store line writer.
// Command and result types, op, color and register codes. No dependencies.
package mfb_lw_pkg;

	localparam int STORE_BYTES_DEF = 8192;
	// byte offsets are held wide enough for any line pixel and for store sizes below 2**17 bytes
	localparam int OFF_W = 17;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 9;

	localparam logic [1:0] OP_LINE = 2'd0;
	localparam logic [1:0] OP_FILL = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;
	localparam logic [1:0] OP_NOP  = 2'd3;

	localparam logic [1:0] COLOR_CLEAR = 2'd0;
	localparam logic [1:0] COLOR_SET   = 2'd1;

	localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_WIDTH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PADDED_ROWS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DRAW_COLOR  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_X    = 3'd4;

	localparam logic [7:0] BYTE_ONES = 8'hFF;
	localparam logic [7:0] PIXEL_MSB = 8'h80;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  x_start;
		logic [7:0]  y_start;
		logic [7:0]  run_length;
		logic        direction;
		logic [12:0] read_address;
	} cmd_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       status;
	} res_t;

endpackage

@@ rtl/core/mono_framebuffer_line_writer_top.sv @@
// Monochrome frame store line writer: byte-wide frame store with line, fill and read commands.
// Depends on mfb_lw_pkg.
//
// One command is taken at a time (start while busy is low) and gives one result, shown for
// a single cycle with done; the receiver cannot stall it. For a line of len pixels, the store
// does one pixel read-modify-write per cycle through a two-step pipeline with write
// forwarding; a line with len 0 or pixel width 0 goes straight to the result. A fill writes
// row stride times padded rows bytes, one store write per cycle, and goes straight to the
// result if dropped or empty. A read returns the byte from the registered store read. The
// unused op goes straight to the result.
// Configuration writes are always ready and must only happen while busy is low.
module mono_framebuffer_line_writer_top
	import mfb_lw_pkg::*;
#(
	parameter int STORE_BYTES = STORE_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  cmd_t                  cmd,
	output logic                  done,
	output res_t                  result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = $clog2(STORE_BYTES);
	localparam logic [OFF_W-1:0] STORE_LIMIT = OFF_W'(STORE_BYTES);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_LINE = 5'b00010,
		ST_FILL = 5'b00100,
		ST_READ = 5'b01000,
		ST_RESP = 5'b10000
	} state_t;

	state_t state_q;
	cmd_t   cmd_q;

	logic [5:0] bpr_q;
	logic [8:0] pw_q;
	logic [8:0] rows_q;
	logic [1:0] color_q;
	logic       mirror_q;

	logic [7:0]       cnt_q;
	logic [OFF_W-1:0] fill_cnt_q;
	logic [OFF_W-1:0] needed_q;
	logic             err_q;
	logic             done_q;
	res_t             result_q;

	logic [7:0] mem_q [STORE_BYTES];
	logic [7:0] rdata_q;

	logic          vld_s1;
	logic [AW-1:0] addr_s1;
	logic [7:0]    mask_s1;
	logic          wr_vld_q;
	logic [AW-1:0] wr_addr_q;
	logic [7:0]    wr_data_q;

	// pixel address generation
	logic [8:0]       col;
	logic [8:0]       row;
	logic [10:0]      mcol;
	logic [8:0]       pcol;
	logic             neg;
	logic [14:0]      row_base;
	logic [OFF_W-1:0] pix_off;
	logic             pix_oob;
	logic [7:0]       pix_mask;
	logic [AW-1:0]    rd_idx;

	logic [14:0]      needed;
	logic             read_ok;
	logic             read_ok_q;
	logic             accept;
	logic             last_pixel;

	logic [7:0] base;
	logic [7:0] set_val;
	logic [7:0] new_val;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = result_q;

	always_comb begin
		col  = {1'b0, cmd_q.x_start} + (cmd_q.direction ? 9'd0 : {1'b0, cnt_q});
		row  = {1'b0, cmd_q.y_start} + (cmd_q.direction ? {1'b0, cnt_q} : 9'd0);
		mcol = {2'b00, pw_q} - 11'd1 - {2'b00, col};
		neg  = mirror_q && mcol[10];
		pcol = mirror_q ? mcol[8:0] : col;
		row_base = 15'({6'd0, row} * {9'd0, bpr_q});
		pix_off  = OFF_W'(row_base) + OFF_W'(pcol[8:3]);
		pix_oob  = neg || (pix_off >= STORE_LIMIT);
		pix_mask = PIXEL_MSB >> pcol[2:0];
	end

	assign needed     = 15'({9'd0, bpr_q} * {6'd0, rows_q});
	assign read_ok    = ({4'd0, cmd.read_address} < STORE_LIMIT);
	assign last_pixel = (cnt_q == (cmd_q.run_length - 8'd1));
	assign rd_idx     = (state_q == ST_IDLE) ? AW'(cmd.read_address) : pix_off[AW-1:0];

	// modify step with forwarding of the last registered write
	always_comb begin
		base    = (wr_vld_q && (wr_addr_q == addr_s1)) ? wr_data_q : rdata_q;
		set_val = (color_q inside {COLOR_CLEAR, COLOR_SET}) ? (base | mask_s1) : base;
		new_val = (color_q != COLOR_SET) ? (set_val ^ mask_s1) : set_val;
	end

	always_comb begin
		if (state_q == ST_FILL) begin
			mem_we    = 1'b1;
			mem_waddr = fill_cnt_q[AW-1:0];
			mem_wdata = BYTE_ONES;
		end else begin
			mem_we    = vld_s1;
			mem_waddr = addr_s1;
			mem_wdata = new_val;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem_q[rd_idx];
	end

	always_ff @(posedge clk) begin
		addr_s1   <= pix_off[AW-1:0];
		mask_s1   <= pix_mask;
		wr_addr_q <= addr_s1;
		wr_data_q <= new_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpr_q    <= 6'd16;
			pw_q     <= 9'd128;
			rows_q   <= 9'd64;
			color_q  <= COLOR_CLEAR;
			mirror_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ROW_STRIDE:  bpr_q    <= cfg_data[5:0];
				CFG_PIXEL_WIDTH: pw_q     <= cfg_data;
				CFG_PADDED_ROWS: rows_q   <= cfg_data;
				CFG_DRAW_COLOR:  color_q  <= cfg_data[1:0];
				CFG_MIRROR_X:    mirror_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			fill_cnt_q <= '0;
			needed_q   <= '0;
			err_q      <= 1'b0;
			read_ok_q  <= 1'b0;
			done_q     <= 1'b0;
			result_q   <= '0;
			vld_s1     <= 1'b0;
			wr_vld_q   <= 1'b0;
			cmd_q      <= '0;
		end else begin
			done_q   <= 1'b0;
			vld_s1   <= (state_q == ST_LINE) && !pix_oob;
			wr_vld_q <= vld_s1;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q      <= cmd;
						cnt_q      <= '0;
						fill_cnt_q <= '0;
						needed_q   <= OFF_W'(needed);
						err_q      <= 1'b0;
						read_ok_q  <= read_ok;
						state_q    <= ST_RESP;
						case (cmd.op)
							OP_LINE: begin
								if (pw_q != 9'd0 && cmd.run_length != 8'd0) begin
									state_q <= ST_LINE;
								end
							end
							OP_FILL: begin
								if (OFF_W'(needed) > STORE_LIMIT) begin
									err_q <= 1'b1;
								end else if (needed != 15'd0) begin
									state_q <= ST_FILL;
								end
							end
							OP_READ: state_q <= ST_READ;
							default: ;
						endcase
					end
				end
				ST_LINE: begin
					if (pix_oob) begin
						err_q <= 1'b1;
					end
					cnt_q <= cnt_q + 8'd1;
					if (last_pixel) begin
						state_q <= ST_RESP;
					end
				end
				ST_FILL: begin
					fill_cnt_q <= fill_cnt_q + OFF_W'(1);
					if (fill_cnt_q == needed_q - OFF_W'(1)) begin
						state_q <= ST_RESP;
					end
				end
				ST_READ: begin
					done_q             <= 1'b1;
					result_q.read_data <= read_ok_q ? rdata_q : 8'd0;
					result_q.status    <= !read_ok_q;
					state_q            <= ST_IDLE;
				end
				ST_RESP: begin
					done_q             <= 1'b1;
					result_q.read_data <= 8'd0;
					result_q.status    <= err_q;
					state_q            <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/core/mfb_lw_checker.sv @@
// Port checker for the monochrome frame store line writer, bound to the top level.
// Depends on mfb_lw_pkg and mono_framebuffer_line_writer_top_macros.svh.
`include "mono_framebuffer_line_writer_top_macros.svh"

module mfb_lw_checker
	import mfb_lw_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input res_t result
);

	// busy is high in the cycle after every accepted command
	`MFB_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after transfer")

	// a result appears only as the command finishes
	`MFB_ASSERT_NOW(a_done_end, done, !busy && $past(busy), "result without a finished command")

	// an error result never carries data
	`MFB_ASSERT_NOW(a_err_nodata, done && result.status, result.read_data == 8'd0,
		"error result carries data")

	// results are single-cycle pulses
	`MFB_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe held")

endmodule

bind mono_framebuffer_line_writer_top mfb_lw_checker u_mfb_lw_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
